FILE: src/crrm_pkg.sv
// crrm_pkg: shared types and codes for the cascaded range remap block
// holds the command and result words and the token and rule-write controls
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package crrm_pkg;

	// action codes of a command word
	localparam logic [1:0] ACT_WRITE     = 2'd0;
	localparam logic [1:0] ACT_TRANSLATE = 2'd1;
	localparam logic [1:0] ACT_RESTART   = 2'd2;

	// wide enough for the largest stage count
	localparam int STAGE_BITS = 4;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  stage_index;
		logic [5:0]  entry_index;
		logic        rule_valid;
		logic [31:0] dest_start;
		logic [31:0] source_start;
		logic [31:0] window_length;
		logic [31:0] seed_value;
	} item_t;

	typedef struct packed {
		logic [31:0] mapped_value;
		logic [31:0] batch_minimum;
	} result_t;

	// control part of the token that walks the cell row
	typedef struct packed {
		logic                  valid;
		logic                  matched;
		logic [STAGE_BITS-1:0] stage;
	} token_ctl_t;

	// rule write broadcast to all cells
	typedef struct packed {
		logic                  we;
		logic [STAGE_BITS-1:0] stage;
		logic [5:0]            entry;
		logic                  rule_valid;
	} rule_wr_t;

endpackage

`default_nettype wire

FILE: src/crrm_cell.sv
// crrm_cell: one rule slot of every remap stage
// checks the passing token against its rule for the token's stage and hands it on
// depends on crrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module crrm_cell #(
	parameter int VALUE_BITS = 32,
	parameter int STAGES     = 7,
	parameter int ENTRY_ID   = 0
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire crrm_pkg::rule_wr_t          wr,
	input  wire logic [VALUE_BITS-1:0]       wr_dest,
	input  wire logic [VALUE_BITS-1:0]       wr_source,
	input  wire logic [VALUE_BITS-1:0]       wr_length,
	input  wire crrm_pkg::token_ctl_t        ctl_in,
	input  wire logic [VALUE_BITS-1:0]       value_in,
	output crrm_pkg::token_ctl_t             ctl_q,
	output logic [VALUE_BITS-1:0]            value_q
);

	localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;

	logic [VALUE_BITS-1:0] dest_q   [STAGES];
	logic [VALUE_BITS-1:0] source_q [STAGES];
	logic [VALUE_BITS-1:0] length_q [STAGES];
	logic [STAGES-1:0]     en_q;

	logic [SW-1:0]         sidx;
	logic [SW-1:0]         widx;
	logic                  wr_hit;
	logic [VALUE_BITS-1:0] offset;
	logic                  hit;

	assign sidx   = ctl_in.stage[SW-1:0];
	assign widx   = wr.stage[SW-1:0];
	assign wr_hit = wr.we && (32'(wr.entry) == ENTRY_ID);

	// window test by wrapped offset, so windows past the top still work
	assign offset = value_in - source_q[sidx];
	assign hit    = ctl_in.valid && !ctl_in.matched && en_q[sidx] &&
	                (offset < length_q[sidx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= '0;
			ctl_q <= '0;
		end else begin
			if (wr_hit) begin
				en_q[widx] <= wr.rule_valid;
			end
			ctl_q.valid   <= ctl_in.valid;
			ctl_q.matched <= ctl_in.matched || hit;
			ctl_q.stage   <= ctl_in.stage;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			dest_q[widx]   <= wr_dest;
			source_q[widx] <= wr_source;
			length_q[widx] <= wr_length;
		end
		value_q <= hit ? (dest_q[sidx] + offset) : value_in;
	end

endmodule

`default_nettype wire

FILE: src/cascaded_range_remap_min_core.sv
// cascaded_range_remap_min_core: a translate word walks the row of ENTRIES cells
// once per stage, one cell a cycle, and done is registered from the tail of the
// last stage; so one translate is in flight at a time.
// rule writes and restarts are taken only while idle; done lasts one cycle, no stall.
// reset clears all rule enables, the token row and sets the batch minimum to ones.
// depends on crrm_pkg and crrm_cell
`timescale 1ns / 1ps
`default_nettype none

module cascaded_range_remap_min_core #(
	parameter int STAGES     = 7,
	parameter int ENTRIES    = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire crrm_pkg::item_t item,
	output logic                 done,
	output crrm_pkg::result_t    result
);

	crrm_pkg::token_ctl_t  ctl_chain   [ENTRIES+1];
	logic [VALUE_BITS-1:0] value_chain [ENTRIES+1];
	logic [ENTRIES-1:0]    token_live;

	crrm_pkg::rule_wr_t    wr;
	crrm_pkg::token_ctl_t  last_ctl;
	logic [VALUE_BITS-1:0] last_value;
	logic [VALUE_BITS-1:0] min_q;
	logic [VALUE_BITS-1:0] min_next;
	logic                  accept;
	logic                  launch;
	logic                  wrap;
	logic                  finish;
	logic                  busy_q;
	logic                  done_q;
	crrm_pkg::result_t     result_q;

	assign accept     = start && !busy_q;
	assign launch     = accept && (item.action == crrm_pkg::ACT_TRANSLATE);
	assign last_ctl   = ctl_chain[ENTRIES];
	assign last_value = value_chain[ENTRIES];
	assign wrap   = last_ctl.valid &&
	                (last_ctl.stage != crrm_pkg::STAGE_BITS'(STAGES - 1));
	assign finish = last_ctl.valid &&
	                (last_ctl.stage == crrm_pkg::STAGE_BITS'(STAGES - 1));
	assign min_next = (last_value < min_q) ? last_value : min_q;

	always_comb begin
		wr.we = accept && (item.action == crrm_pkg::ACT_WRITE) &&
		        (32'(item.stage_index) < STAGES) &&
		        (32'(item.entry_index) < ENTRIES);
		wr.stage      = crrm_pkg::STAGE_BITS'(item.stage_index);
		wr.entry      = item.entry_index;
		wr.rule_valid = item.rule_valid;
	end

	// head of the row: a fresh word, or the word back from the tail for the next stage
	always_comb begin
		priority if (launch) begin
			ctl_chain[0].valid   = 1'b1;
			ctl_chain[0].matched = 1'b0;
			ctl_chain[0].stage   = '0;
			value_chain[0]       = VALUE_BITS'(item.seed_value);
		end else if (wrap) begin
			ctl_chain[0].valid   = 1'b1;
			ctl_chain[0].matched = 1'b0;
			ctl_chain[0].stage   = last_ctl.stage + crrm_pkg::STAGE_BITS'(1);
			value_chain[0]       = last_value;
		end else begin
			ctl_chain[0]   = '0;
			value_chain[0] = last_value;
		end
	end

	for (genvar e = 0; e < ENTRIES; e++) begin : g_cell
		crrm_cell #(
			.VALUE_BITS (VALUE_BITS),
			.STAGES     (STAGES),
			.ENTRY_ID   (e)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr        (wr),
			.wr_dest   (VALUE_BITS'(item.dest_start)),
			.wr_source (VALUE_BITS'(item.source_start)),
			.wr_length (VALUE_BITS'(item.window_length)),
			.ctl_in    (ctl_chain[e]),
			.value_in  (value_chain[e]),
			.ctl_q     (ctl_chain[e+1]),
			.value_q   (value_chain[e+1])
		);
		assign token_live[e] = ctl_chain[e+1].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			min_q  <= '1;
		end else begin
			done_q <= finish;
			if (launch) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (accept && (item.action == crrm_pkg::ACT_RESTART)) begin
				min_q <= '1;
			end else if (finish) begin
				min_q <= min_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q.mapped_value  <= 32'(last_value);
			result_q.batch_minimum <= 32'(min_next);
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	// at most one word walks the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(token_live))
		else $error("more than one word in the cell row");

	// nothing in the row while idle
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (token_live == '0))
		else $error("word in the cell row while idle");

	a_launch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		launch |=> busy_q)
		else $error("translate accepted without going busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result word while still busy");

endmodule

`default_nettype wire

FILE: tb/cascaded_range_remap_min_core_test.sv
// cascaded_range_remap_min_core_test: self-checking bench for the cascaded range remap block
// predicts every translate result from its own copy of the rule tables and batch minimum
// depends on crrm_pkg and cascaded_range_remap_min_core
`timescale 1ns / 1ps

module cascaded_range_remap_min_core_test;

	localparam int N_STAGES = 7;
	localparam int N_ENTRIES = 64;
	localparam int RANDOM_WORDS = 1830;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// holds the predicted rule tables and the batch minimum, checks each result word
	class remap_scoreboard;
		logic [31:0] rule_dst [N_STAGES][N_ENTRIES];
		logic [31:0] rule_src [N_STAGES][N_ENTRIES];
		logic [31:0] rule_len [N_STAGES][N_ENTRIES];
		bit          rule_on  [N_STAGES][N_ENTRIES];
		logic [31:0] batch_min;
		crrm_pkg::result_t pending_results [$];
		int errors, writes, translates, restarts, ignored, checked;

		function new();
			foreach (rule_on[s, e]) rule_on[s][e] = 1'b0;
			batch_min = '1;
			errors = 0;
			writes = 0;
			translates = 0;
			restarts = 0;
			ignored = 0;
			checked = 0;
		endfunction

		function logic [31:0] run_chain(logic [31:0] seed);
			logic [31:0] v;
			logic [31:0] off;
			bit hit;
			v = seed;
			for (int s = 0; s < N_STAGES; s++) begin
				hit = 1'b0;
				for (int e = 0; e < N_ENTRIES && !hit; e++) begin
					// offset test also covers windows that wrap past the top
					off = v - rule_src[s][e];
					if (rule_on[s][e] && off < rule_len[s][e]) begin
						v = rule_dst[s][e] + off;
						hit = 1'b1;
					end
				end
			end
			return v;
		endfunction

		function void note_word(crrm_pkg::item_t w);
			crrm_pkg::result_t r;
			case (w.action)
				crrm_pkg::ACT_WRITE: begin
					writes++;
					if (w.stage_index < N_STAGES) begin
						rule_dst[w.stage_index][w.entry_index] = w.dest_start;
						rule_src[w.stage_index][w.entry_index] = w.source_start;
						rule_len[w.stage_index][w.entry_index] = w.window_length;
						rule_on[w.stage_index][w.entry_index] = w.rule_valid;
					end
				end
				crrm_pkg::ACT_TRANSLATE: begin
					translates++;
					r.mapped_value = run_chain(w.seed_value);
					if (r.mapped_value < batch_min)
						batch_min = r.mapped_value;
					r.batch_minimum = batch_min;
					pending_results.push_back(r);
				end
				crrm_pkg::ACT_RESTART: begin
					restarts++;
					batch_min = '1;
				end
				default: ignored++;
			endcase
		endfunction

		function void check_result(crrm_pkg::result_t got);
			crrm_pkg::result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, mapped %h minimum %h",
					$time, got.mapped_value, got.batch_minimum);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.mapped_value !== want.mapped_value) begin
				errors++;
				$display("%0t: mapped_value expected %h actual %h",
					$time, want.mapped_value, got.mapped_value);
			end
			if (got.batch_minimum !== want.batch_minimum) begin
				errors++;
				$display("%0t: batch_minimum expected %h actual %h",
					$time, want.batch_minimum, got.batch_minimum);
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	crrm_pkg::item_t item = '0;
	logic busy;
	logic done;
	crrm_pkg::result_t result;

	remap_scoreboard sb = new();
	int idle_pct = 0;
	logic [31:0] anchors [8];

	cascaded_range_remap_min_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_word(item);
		end
	end

	initial begin
		#40_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic send_word(input crrm_pkg::item_t w);
		int gap;
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			gap = $urandom_range(1, 16);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
	endtask

	function automatic crrm_pkg::item_t write_word(logic [2:0] stage, logic [5:0] entry,
		logic on, logic [31:0] dst, logic [31:0] src, logic [31:0] len);
		crrm_pkg::item_t w;
		w = '0;
		w.action = crrm_pkg::ACT_WRITE;
		w.stage_index = stage;
		w.entry_index = entry;
		w.rule_valid = on;
		w.dest_start = dst;
		w.source_start = src;
		w.window_length = len;
		return w;
	endfunction

	function automatic crrm_pkg::item_t plain_word(logic [1:0] action, logic [31:0] seed);
		crrm_pkg::item_t w;
		w = '0;
		w.action = action;
		w.seed_value = seed;
		return w;
	endfunction

	// values cluster round a few anchors so windows and seeds meet often
	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return anchors[$urandom_range(0, 7)] + $urandom_range(0, 511) - 32'd128;
	endfunction

	function automatic logic [31:0] pick_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return '0;
		if (r == 2)
			return $urandom;
		if (r == 3)
			return 32'hFFFF_FFFF - $urandom_range(0, 15);
		return $urandom_range(1, 1024);
	endfunction

	function automatic crrm_pkg::item_t random_word();
		crrm_pkg::item_t w;
		int r;
		w.stage_index = 3'($urandom_range(0, 7));
		w.entry_index = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 63))
		                                            : 6'($urandom_range(0, 7));
		w.rule_valid = ($urandom_range(0, 4) != 0);
		w.dest_start = ($urandom_range(0, 1) == 0) ? pick_value() : $urandom;
		w.source_start = pick_value();
		w.window_length = pick_length();
		w.seed_value = pick_value();
		r = $urandom_range(0, 99);
		if (r < 40)
			w.action = crrm_pkg::ACT_WRITE;
		else if (r < 85)
			w.action = crrm_pkg::ACT_TRANSLATE;
		else if (r < 93)
			w.action = crrm_pkg::ACT_RESTART;
		else
			w.action = ACT_UNUSED;
		return w;
	endfunction

	initial begin
		int counted;
		crrm_pkg::item_t w;
		crrm_pkg::item_t ones;

		ones = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 30;
		// empty tables pass the value straight through
		send_word(plain_word(crrm_pkg::ACT_TRANSLATE, 32'hFFFF_FFFF));
		// window wrapping past the top of the value range
		send_word(write_word(3'd0, 6'd5, 1'b1, 32'h0000_1000, 32'hFFFF_FF00, 32'h200));
		send_word(plain_word(crrm_pkg::ACT_TRANSLATE, 32'h0000_0010));
		send_word(plain_word(crrm_pkg::ACT_TRANSLATE, 32'hFFFF_FF00));
		// lower slot wins on overlap
		send_word(write_word(3'd0, 6'd2, 1'b1, 32'h0000_0007, 32'hFFFF_FFF0, 32'h10));
		send_word(plain_word(crrm_pkg::ACT_TRANSLATE, 32'hFFFF_FFF5));
		// chain into the last slot of the last stage
		send_word(write_word(3'd6, 6'd63, 1'b1, 32'hFFFF_FFFF, 32'h0000_1000, 32'h1));
		send_word(plain_word(crrm_pkg::ACT_TRANSLATE, 32'hFFFF_FF00));
		// zero length window matches nothing
		send_word(write_word(3'd3, 6'd0, 1'b1, 32'h1234_5678, 32'h0, 32'h0));
		send_word(plain_word(crrm_pkg::ACT_TRANSLATE, 32'h0));
		// stage out of range is dropped
		send_word(write_word(3'd7, 6'd0, 1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF));
		// clearing a slot with all-ones words
		send_word(write_word(3'd0, 6'd5, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_word(plain_word(crrm_pkg::ACT_TRANSLATE, 32'h0000_0010));
		w = ones;
		w.action = ACT_UNUSED;
		send_word(w);
		send_word(plain_word(crrm_pkg::ACT_RESTART, 32'h0));
		send_word(plain_word(crrm_pkg::ACT_TRANSLATE, 32'hFFFF_FFFF));
		// full-length window in stage one: everything but the top value moves down by one
		send_word(write_word(3'd1, 6'd0, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
		send_word(plain_word(crrm_pkg::ACT_TRANSLATE, 32'h0));
		send_word(plain_word(crrm_pkg::ACT_TRANSLATE, 32'hFFFF_FFFF));
		w = ones;
		w.action = crrm_pkg::ACT_TRANSLATE;
		send_word(w);
		send_word(write_word(3'd1, 6'd0, 1'b0, 32'h0, 32'h0, 32'h0));
		send_word(plain_word(crrm_pkg::ACT_RESTART, 32'h0));

		anchors[0] = 32'h0;
		anchors[1] = 32'hFFFF_FF80;
		for (int i = 2; i < 8; i++) anchors[i] = $urandom;

		counted = 0;
		while (counted < RANDOM_WORDS) begin
			if (counted % 150 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 40;
				endcase
			end
			if (counted >= RANDOM_WORDS * 85 / 100)
				idle_pct = 0;
			w = random_word();
			send_word(w);
			counted++;
		end
		start <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (N_STAGES * N_ENTRIES + 8) @(posedge clk);

		$display("covered %0d rule writes, %0d translates, %0d restarts, %0d unused codes",
			sb.writes, sb.translates, sb.restarts, sb.ignored);
		$display("%0d result words checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
